>>> hdl/assert_macros.svh
// assertion macros shared by the touch filter modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/tsfe_pkg.sv
// types and constants of the touch sample filter and event block
// no dependencies
package tsfe_pkg;

    localparam int LIMIT_W    = 12;
    localparam int SIDE_W     = 10;
    localparam int POINT_W    = 10;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int BATCH_LEN  = 5;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = LIMIT_W + SIDE_W;

    localparam logic               ORIENT_HORIZONTAL = 1'b1;

    localparam logic               RST_ORIENTATION = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_X_LOW  = LIMIT_W'(400);
    localparam logic [LIMIT_W-1:0] RST_X_HIGH = LIMIT_W'(3800);
    localparam logic [LIMIT_W-1:0] RST_Y_LOW  = LIMIT_W'(255);
    localparam logic [LIMIT_W-1:0] RST_Y_HIGH = LIMIT_W'(3750);
    localparam logic [SIDE_W-1:0]  RST_SHORT  = SIDE_W'(240);
    localparam logic [SIDE_W-1:0]  RST_LONG   = SIDE_W'(320);

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN,
        EV_MOVE,
        EV_UP
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIENTATION,
        REG_X_LOW,
        REG_X_HIGH,
        REG_Y_LOW,
        REG_Y_HIGH,
        REG_SHORT_SIDE,
        REG_LONG_SIDE
    } cfg_index_t;

    typedef struct packed {
        logic               orientation;
        logic [LIMIT_W-1:0] x_low_limit;
        logic [LIMIT_W-1:0] x_high_limit;
        logic [LIMIT_W-1:0] y_low_limit;
        logic [LIMIT_W-1:0] y_high_limit;
        logic [SIDE_W-1:0]  screen_short_side;
        logic [SIDE_W-1:0]  screen_long_side;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_MUL,
        S_SCALE,
        S_SCALE_WAIT,
        S_MAP,
        S_EMIT
    } state_t;

endpackage

>>> hdl/tsfe_if.sv
// channel interfaces of the touch filter: samples, events, register writes
// depends on tsfe_pkg
interface tsfe_sample_if #(parameter int RAW_BITS = 12);
    import tsfe_pkg::*;

    logic                valid;
    logic                ready;
    logic                pen_down;
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;

    modport source (output valid, pen_down, raw_x, raw_y, input ready);
    modport sink (input valid, pen_down, raw_x, raw_y, output ready);
endinterface

interface tsfe_event_if;
    import tsfe_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;

    modport source (output valid, event_kind, point_x, point_y, input ready);
    modport sink (input valid, event_kind, point_x, point_y, output ready);
endinterface

interface tsfe_cfg_if;
    import tsfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/touch_sample_filter_event_core.sv
// top level of the touch sample filter and event generator
// depends on tsfe_pkg, tsfe_if, tsfe_cfg_regs, tsfe_div and assert_macros.svh
//
// smp carries raw samples (pen_down, raw_x, raw_y), evt carries events
// (event_kind, point_x, point_y), cfg writes the seven setup registers.
// An item is taken on smp when valid and ready are high at a clock edge.
// A pen-down sample that does not close a batch is stored, and smp stays
// ready for the next one. The fifth sample of a batch starts the sequencer:
// per axis a scan for min, max and sum, the divide by three through a
// reciprocal multiply, a clamp and multiply, and a divide by the window
// width on a shared divider that returns one quotient bit per cycle. An
// axis with a zero-width or inverted window skips the divider and scales
// to zero. After both axes the point is mapped to the screen and, if it
// changed, passes through S_EMIT to the event register; smp takes no sample meanwhile.
// A pen-up sample during a touch loads its touch-up event in S_EMIT once the slot is free.
// The event sits in an output register; smp takes the next sample while
// it waits, and only a new event stalls until evt takes the old one.
// Reset returns the setup registers to their defaults, drops the batch
// and clears the active-touch state.
module touch_sample_filter_event_core #(
    parameter int RAW_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    tsfe_sample_if.sink   smp,
    tsfe_event_if.source  evt,
    tsfe_cfg_if.sink      cfg
);
    import tsfe_pkg::*;
    `include "assert_macros.svh"

    localparam int TOT_W  = RAW_BITS + 3;
    localparam int SUM3_W = RAW_BITS + 2;
    localparam int MUL3_W = 2 * SUM3_W;
    localparam int DIV_W  = PROD_W;
    localparam int CW     = (RAW_BITS > LIMIT_W) ? RAW_BITS : LIMIT_W;

    // ceil(2^(SUM3_W+1) / 3), exact for every SUM3_W-bit dividend
    localparam logic [SUM3_W-1:0] RECIP3 =
        SUM3_W'(((64'd1 << (SUM3_W + 1)) + 64'd2) / 64'd3);

    cfg_t      regs;
    div_stat_t div_stat;
    logic [DIV_W-1:0]   div_quotient;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [LIMIT_W-1:0] div_divisor;

    state_t state_reg;
    state_t state_next;

    logic [RAW_BITS-1:0] batch_x_store_reg [BATCH_LEN];
    logic [RAW_BITS-1:0] batch_y_store_reg [BATCH_LEN];
    logic [IDX_W-1:0]    batch_count_reg;
    logic                touch_active_reg;
    logic [POINT_W-1:0]  last_x_reg;
    logic [POINT_W-1:0]  last_y_reg;
    logic                axis_reg;
    logic [IDX_W-1:0]    k_reg;

    logic [RAW_BITS-1:0] lo_reg;
    logic [RAW_BITS-1:0] hi_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [RAW_BITS-1:0] filt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                win_ok_reg;
    logic [LIMIT_W-1:0]  width_reg;
    logic [POINT_W-1:0]  sx_reg;
    logic [POINT_W-1:0]  sy_reg;
    event_kind_t         pend_kind_reg;
    logic [POINT_W-1:0]  pend_x_reg;
    logic [POINT_W-1:0]  pend_y_reg;

    logic                out_valid_reg;
    event_kind_t         out_kind_reg;
    logic [POINT_W-1:0]  out_x_reg;
    logic [POINT_W-1:0]  out_y_reg;

    logic                in_ready;
    logic                emit_load;
    logic                accept;
    logic                slot_free;
    logic                axis_done;
    logic                changed;
    logic [RAW_BITS-1:0] cur;
    logic [SUM3_W-1:0]   sum3;
    logic [MUL3_W-1:0]   sum3_prod;
    logic [RAW_BITS-1:0] sum3_div3;
    logic [LIMIT_W-1:0]  lim_low;
    logic [LIMIT_W-1:0]  lim_high;
    logic [SIDE_W-1:0]   lim_side;
    logic [CW-1:0]       v_ext;
    logic [CW-1:0]       lo_ext;
    logic [CW-1:0]       hi_ext;
    logic [CW-1:0]       clamped;
    logic [LIMIT_W-1:0]  off;
    logic [POINT_W-1:0]  map_x;
    logic [POINT_W-1:0]  map_y;

    tsfe_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tsfe_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (LIMIT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign accept    = smp.valid && in_ready;
    assign slot_free = !out_valid_reg || evt.ready;
    assign axis_done = (state_reg == S_SCALE && !win_ok_reg)
                    || (state_reg == S_SCALE_WAIT && div_stat.done);

    assign cur  = axis_reg ? batch_y_store_reg[k_reg] : batch_x_store_reg[k_reg];
    assign sum3 = SUM3_W'(total_reg - TOT_W'(lo_reg) - TOT_W'(hi_reg));

    // divide by three as multiply and shift
    assign sum3_prod = MUL3_W'(sum3) * MUL3_W'(RECIP3);
    assign sum3_div3 = RAW_BITS'(sum3_prod >> (SUM3_W + 1));

    // per-axis window and screen side
    assign lim_low  = axis_reg ? regs.y_low_limit  : regs.x_low_limit;
    assign lim_high = axis_reg ? regs.y_high_limit : regs.x_high_limit;
    assign lim_side = axis_reg ? regs.screen_short_side : regs.screen_long_side;
    assign v_ext    = CW'(filt_reg);
    assign lo_ext   = CW'(lim_low);
    assign hi_ext   = CW'(lim_high);
    assign clamped  = (v_ext > hi_ext) ? hi_ext : ((v_ext < lo_ext) ? lo_ext : v_ext);
    assign off      = LIMIT_W'(clamped - lo_ext);

    always_comb
    begin
        if (regs.orientation == ORIENT_HORIZONTAL)
        begin
            map_x = sx_reg;
            map_y = regs.screen_short_side - sy_reg;
        end
        else
        begin
            map_x = regs.screen_short_side - sy_reg;
            map_y = regs.screen_long_side - sx_reg;
        end
    end

    assign changed = !touch_active_reg || (map_x != last_x_reg) || (map_y != last_y_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!smp.pen_down)
                        state_next = touch_active_reg ? S_EMIT : S_IDLE;
                    else if (batch_count_reg == IDX_W'(BATCH_LEN - 1))
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (k_reg == IDX_W'(BATCH_LEN - 1))
                    state_next = S_TRIM;
            end
            S_TRIM:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (!win_ok_reg)
                    state_next = axis_reg ? S_MAP : S_SCAN;
                else
                    state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (div_stat.done)
                    state_next = axis_reg ? S_MAP : S_SCAN;
            end
            S_MAP:
            begin
                state_next = changed ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready     = 1'b0;
        emit_load    = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = width_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCALE:
            begin
                div_start = win_ok_reg;
            end
            S_EMIT:
            begin
                emit_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign smp.ready      = in_ready;
    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = out_kind_reg;
    assign evt.point_x    = out_x_reg;
    assign evt.point_y    = out_y_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            batch_count_reg  <= '0;
            touch_active_reg <= 1'b0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            axis_reg         <= 1'b0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                if (!smp.pen_down)
                begin
                    batch_count_reg  <= '0;
                    touch_active_reg <= 1'b0;
                end
                else if (batch_count_reg == IDX_W'(BATCH_LEN - 1))
                    batch_count_reg <= '0;
                else
                    batch_count_reg <= batch_count_reg + IDX_W'(1);
            end

            if (state_reg == S_SCAN)
                k_reg <= (k_reg == IDX_W'(BATCH_LEN - 1)) ? '0 : k_reg + IDX_W'(1);

            if (axis_done)
                axis_reg <= !axis_reg;

            if (state_reg == S_MAP)
            begin
                touch_active_reg <= 1'b1;
                if (changed)
                begin
                    last_x_reg <= map_x;
                    last_y_reg <= map_y;
                end
            end

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept && smp.pen_down)
        begin
            batch_x_store_reg[batch_count_reg] <= smp.raw_x;
            batch_y_store_reg[batch_count_reg] <= smp.raw_y;
        end

        if (accept && !smp.pen_down)
        begin
            pend_kind_reg <= EV_UP;
            pend_x_reg    <= last_x_reg;
            pend_y_reg    <= last_y_reg;
        end

        // first minimum and first maximum, strict compares
        if (state_reg == S_SCAN)
        begin
            if (k_reg == '0)
            begin
                lo_reg    <= cur;
                hi_reg    <= cur;
                total_reg <= TOT_W'(cur);
            end
            else
            begin
                if (cur < lo_reg)
                    lo_reg <= cur;
                if (cur > hi_reg)
                    hi_reg <= cur;
                total_reg <= total_reg + TOT_W'(cur);
            end
        end

        // all five equal passes the value through
        if (state_reg == S_TRIM)
            filt_reg <= (lo_reg == hi_reg) ? lo_reg : sum3_div3;

        if (state_reg == S_MUL)
        begin
            prod_reg   <= PROD_W'(off) * PROD_W'(lim_side);
            win_ok_reg <= lim_high > lim_low;
            width_reg  <= lim_high - lim_low;
        end

        if (state_reg == S_SCALE && !win_ok_reg)
        begin
            if (axis_reg)
                sy_reg <= '0;
            else
                sx_reg <= '0;
        end
        if (state_reg == S_SCALE_WAIT && div_stat.done)
        begin
            if (axis_reg)
                sy_reg <= POINT_W'(div_quotient);
            else
                sx_reg <= POINT_W'(div_quotient);
        end

        if (state_reg == S_MAP && changed)
        begin
            pend_kind_reg <= touch_active_reg ? EV_MOVE : EV_DOWN;
            pend_x_reg    <= map_x;
            pend_y_reg    <= map_y;
        end

        if (emit_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
        end
    end

    `ASSERT_HOLDS(a_count_range, batch_count_reg < IDX_W'(BATCH_LEN))
    `ASSERT_IMPLIES(a_start_when_free, div_start, !div_stat.busy)
    `ASSERT_IMPLIES(a_done_expected, div_stat.done, state_reg == S_SCALE_WAIT)

endmodule

>>> hdl/tsfe_cfg_regs.sv
// configuration register bank of the touch filter
// depends on tsfe_pkg and tsfe_cfg_if
module tsfe_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tsfe_cfg_if.sink      cfg,
    output tsfe_pkg::cfg_t regs
);
    import tsfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ORIENTATION: cfg_next.orientation       = cfg.data[0];
                REG_X_LOW:       cfg_next.x_low_limit       = cfg.data[LIMIT_W-1:0];
                REG_X_HIGH:      cfg_next.x_high_limit      = cfg.data[LIMIT_W-1:0];
                REG_Y_LOW:       cfg_next.y_low_limit       = cfg.data[LIMIT_W-1:0];
                REG_Y_HIGH:      cfg_next.y_high_limit      = cfg.data[LIMIT_W-1:0];
                REG_SHORT_SIDE:  cfg_next.screen_short_side = cfg.data[SIDE_W-1:0];
                REG_LONG_SIDE:   cfg_next.screen_long_side  = cfg.data[SIDE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orientation       <= RST_ORIENTATION;
            cfg_reg.x_low_limit       <= RST_X_LOW;
            cfg_reg.x_high_limit      <= RST_X_HIGH;
            cfg_reg.y_low_limit       <= RST_Y_LOW;
            cfg_reg.y_high_limit      <= RST_Y_HIGH;
            cfg_reg.screen_short_side <= RST_SHORT;
            cfg_reg.screen_long_side  <= RST_LONG;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/tsfe_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on tsfe_pkg and assert_macros.svh
module tsfe_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0]      divisor,
    output logic [DIVIDEND_W-1:0]     quotient,
    output tsfe_pkg::div_stat_t       stat
);
    import tsfe_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    assign quo_next = {quo_reg[DIVIDEND_W-2:0], fits};

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    `ASSERT_IMPLIES(a_done_not_busy, done_reg, !busy_reg)
    `ASSERT_NEXT(a_divisor_held, busy_reg, $stable(dvs_reg))

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench for touch_sample_filter_event_core: streams raw touch samples and register
// writes, predicts each touch event with its own trimmed-mean filter and compares
// depends on tsfe_pkg, tsfe_if and the core
module testbench;
    import tsfe_pkg::*;

    localparam int RAW_W            = 12;
    localparam int MAX_GAP          = 8;
    localparam int SETTLE_CYCLES    = 250;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_CLUSTER,
        SHAPE_FLAT,
        SHAPE_EDGE
    } batch_shape_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
    } touch_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tsfe_sample_if #(.RAW_BITS(RAW_W)) sample_ch ();
    tsfe_event_if                      event_ch ();
    tsfe_cfg_if                        reg_ch ();

    touch_sample_filter_event_core #(.RAW_BITS(RAW_W)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (sample_ch),
        .evt   (event_ch),
        .cfg   (reg_ch)
    );

    always #6 clk = ~clk;

    // filter state and setup registers as the block should hold them
    logic                             orient;
    logic [LIMIT_W-1:0]               x_lo, x_hi, y_lo, y_hi;
    logic [SIDE_W-1:0]                short_side, long_side;
    logic [BATCH_LEN-1:0][RAW_W-1:0]  x_batch, y_batch;
    int unsigned                      fill;
    bit                               touching;
    logic [POINT_W-1:0]               last_x, last_y;

    touch_event_t pending_events[$];

    int errors       = 0;
    int n_samples    = 0;
    int n_reg_writes = 0;
    int n_settings   = 0;
    int n_down       = 0;
    int n_move       = 0;
    int n_up         = 0;

    int rx_wait   = 0;
    int hold_left = 0;
    bit no_gaps   = 1'b0;

    logic [RAW_W-1:0] drift_x, drift_y;

    task automatic reset_filter_state();
        orient     = RST_ORIENTATION;
        x_lo       = RST_X_LOW;
        x_hi       = RST_X_HIGH;
        y_lo       = RST_Y_LOW;
        y_hi       = RST_Y_HIGH;
        short_side = RST_SHORT;
        long_side  = RST_LONG;
        x_batch    = '0;
        y_batch    = '0;
        fill       = 0;
        touching   = 1'b0;
        last_x     = '0;
        last_y     = '0;
    endtask

    function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ORIENTATION: orient     = data[0];
            REG_X_LOW:       x_lo       = data[LIMIT_W-1:0];
            REG_X_HIGH:      x_hi       = data[LIMIT_W-1:0];
            REG_Y_LOW:       y_lo       = data[LIMIT_W-1:0];
            REG_Y_HIGH:      y_hi       = data[LIMIT_W-1:0];
            REG_SHORT_SIDE:  short_side = data[SIDE_W-1:0];
            REG_LONG_SIDE:   long_side  = data[SIDE_W-1:0];
            default: ;
        endcase
    endfunction

    // drop first min and first max, average the rest; all equal passes through
    function automatic logic [RAW_W-1:0] trimmed_mean(input logic [BATCH_LEN-1:0][RAW_W-1:0] v);
        int unsigned lo_val;
        int unsigned hi_val;
        int unsigned sum;
        int          ilo;
        int          ihi;
        lo_val = 1 << RAW_W;
        hi_val = 0;
        sum    = 0;
        ilo    = 0;
        ihi    = 0;
        for (int k = 0; k < BATCH_LEN; k++)
        begin
            if (v[k] < lo_val)
            begin
                lo_val = v[k];
                ilo    = k;
            end
            if (v[k] > hi_val)
            begin
                hi_val = v[k];
                ihi    = k;
            end
        end
        if (ilo == ihi)
            return v[ilo];
        for (int k = 0; k < BATCH_LEN; k++)
        begin
            if (k != ilo && k != ihi)
                sum += v[k];
        end
        return RAW_W'(sum / 3);
    endfunction

    function automatic logic [SIDE_W-1:0] scale_axis(input logic [LIMIT_W-1:0] v,
                                                     input logic [LIMIT_W-1:0] lo_lim,
                                                     input logic [LIMIT_W-1:0] hi_lim,
                                                     input logic [SIDE_W-1:0]  side);
        int unsigned c;
        if (hi_lim <= lo_lim)
            return '0;
        c = v;
        if (v > hi_lim)
            c = hi_lim;
        else if (v < lo_lim)
            c = lo_lim;
        return SIDE_W'(((c - lo_lim) * side) / (hi_lim - lo_lim));
    endfunction

    // advances the filter by one sample, returns 1 when an event is due
    function automatic bit filter_sample(input logic pen, input logic [RAW_W-1:0] rx,
                                         input logic [RAW_W-1:0] ry, output touch_event_t ev);
        logic [SIDE_W-1:0]  sx, sy;
        logic [POINT_W-1:0] px, py;
        logic [RAW_W-1:0]   fx, fy;
        ev = '0;
        if (!pen)
        begin
            fill = 0;
            if (touching)
            begin
                touching = 1'b0;
                ev.kind  = EV_UP;
                ev.x     = last_x;
                ev.y     = last_y;
                return 1'b1;
            end
            return 1'b0;
        end
        if (fill >= BATCH_LEN)
            fill = 0;
        x_batch[fill] = rx;
        y_batch[fill] = ry;
        fill++;
        if (fill < BATCH_LEN)
            return 1'b0;
        fill = 0;
        fx = trimmed_mean(x_batch);
        fy = trimmed_mean(y_batch);
        sx = scale_axis(fx, x_lo, x_hi, long_side);
        sy = scale_axis(fy, y_lo, y_hi, short_side);
        if (orient == ORIENT_HORIZONTAL)
        begin
            px = sx;
            py = short_side - sy;
        end
        else
        begin
            px = short_side - sy;
            py = long_side - sx;
        end
        if (!touching || px != last_x || py != last_y)
        begin
            ev.kind  = touching ? EV_MOVE : EV_DOWN;
            ev.x     = px;
            ev.y     = py;
            last_x   = px;
            last_y   = py;
            touching = 1'b1;
            return 1'b1;
        end
        touching = 1'b1;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        touch_event_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("event kind %0d at (%0d,%0d) with none pending",
                                          event_ch.event_kind, event_ch.point_x,
                                          event_ch.point_y));
            else
            begin
                want = pending_events.pop_front();
                if (event_ch.event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, expected %0d",
                                              event_ch.event_kind, want.kind));
                if (event_ch.point_x !== want.x)
                    report_mismatch($sformatf("point_x %0d, expected %0d",
                                              event_ch.point_x, want.x));
                if (event_ch.point_y !== want.y)
                    report_mismatch($sformatf("point_y %0d, expected %0d",
                                              event_ch.point_y, want.y));
                case (want.kind)
                    EV_DOWN: n_down++;
                    EV_MOVE: n_move++;
                    default: n_up++;
                endcase
            end
        end
    end

    // event receiver: random wait per item, or a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            event_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            event_ch.ready <= 1'b0;
        end
        else
        begin
            if (event_ch.valid && event_ch.ready)
                rx_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_wait > 0)
            begin
                rx_wait--;
                event_ch.ready <= 1'b0;
            end
            else
                event_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic pen, input logic [RAW_W-1:0] rx,
                               input logic [RAW_W-1:0] ry);
        int           gap;
        touch_event_t ev;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.pen_down <= pen;
        sample_ch.raw_x    <= rx;
        sample_ch.raw_y    <= ry;
        do @(posedge clk); while (!sample_ch.ready);
        n_samples++;
        if (filter_sample(pen, rx, ry, ev))
            pending_events.push_back(ev);
    endtask

    task automatic wait_for_events();
        sample_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_for_events();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        do @(posedge clk); while (!reg_ch.ready);
        set_register(idx, data);
        n_reg_writes++;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] o, input logic [CFG_DATA_W-1:0] xl,
                                 input logic [CFG_DATA_W-1:0] xh, input logic [CFG_DATA_W-1:0] yl,
                                 input logic [CFG_DATA_W-1:0] yh, input logic [CFG_DATA_W-1:0] s,
                                 input logic [CFG_DATA_W-1:0] l, input bit touch_unused);
        settle();
        write_reg(REG_ORIENTATION, o);
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        write_reg(REG_SHORT_SIDE, s);
        write_reg(REG_LONG_SIDE, l);
        if (touch_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
        reg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [RAW_W-1:0] pick_extreme();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0:       return '0;
            1:       return '1;
            2:       return RAW_W'($urandom_range(0, 15));
            default: return RAW_W'(4095 - $urandom_range(0, 15));
        endcase
    endfunction

    function automatic batch_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SHAPE_CLUSTER;
        if (r < 70)
            return SHAPE_RANDOM;
        if (r < 85)
            return SHAPE_FLAT;
        return SHAPE_EDGE;
    endfunction

    task automatic send_batch(input batch_shape_t shape);
        logic [RAW_W-1:0] bx, by, vx, vy;
        bx = RAW_W'($urandom_range(0, 4095));
        by = RAW_W'($urandom_range(0, 4095));
        for (int k = 0; k < BATCH_LEN; k++)
        begin
            case (shape)
                SHAPE_CLUSTER:
                begin
                    vx = drift_x + RAW_W'($urandom_range(0, 2));
                    vy = drift_y + RAW_W'($urandom_range(0, 2));
                end
                SHAPE_FLAT:
                begin
                    vx = bx;
                    vy = by;
                end
                SHAPE_EDGE:
                begin
                    vx = pick_extreme();
                    vy = pick_extreme();
                end
                default:
                begin
                    vx = RAW_W'($urandom_range(0, 4095));
                    vy = RAW_W'($urandom_range(0, 4095));
                end
            endcase
            send_sample(1'b1, vx, vy);
        end
    endtask

    task automatic test_directed();
        logic [BATCH_LEN-1:0][RAW_W-1:0] dup_x, dup_y;
        dup_x = {12'd2000, 12'd4000, 12'd100, 12'd4000, 12'd100};
        dup_y = {12'd500, 12'd3000, 12'd500, 12'd3000, 12'd3000};
        // pen-up with no touch active
        send_sample(1'b0, 12'hFFF, 12'h000);
        // all zero: passes through, clamps to the low limits
        repeat (BATCH_LEN) send_sample(1'b1, 12'h000, 12'h000);
        // all full scale: clamps to the high limits, move
        repeat (BATCH_LEN) send_sample(1'b1, 12'hFFF, 12'hFFF);
        // same point again: no event
        repeat (BATCH_LEN) send_sample(1'b1, 12'hFFF, 12'hFFF);
        // partial batch dropped by pen-up, touch up at last point
        send_sample(1'b1, 12'h123, 12'h456);
        send_sample(1'b1, 12'h789, 12'hABC);
        send_sample(1'b0, 12'h000, 12'hFFF);
        // repeated minimum and maximum values
        for (int k = 0; k < BATCH_LEN; k++)
            send_sample(1'b1, dup_x[k], dup_y[k]);
    endtask

    task automatic run_batches(input int count);
        repeat (count)
        begin
            send_batch(pick_shape());
            if ($urandom_range(0, 3) == 0)
                send_sample(1'b0, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic test_settings();
        // vertical, full-range windows, largest screen
        apply_setting(12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1023, 12'd1023, 1'b1);
        run_batches(8);
        // zero-width x window, inverted y window, zero screen sides
        apply_setting(12'd1, 12'd2000, 12'd2000, 12'd3000, 12'd1000, 12'd0, 12'd0, 1'b0);
        run_batches(6);
        // narrowest windows, one-pixel screen
        apply_setting(12'd0, 12'd2047, 12'd2048, 12'd0, 12'd1, 12'd1, 12'd1, 1'b0);
        run_batches(8);
        // upper data bits beyond the register widths
        apply_setting(12'hFFE, 12'h0FF, 12'hF00, 12'h010, 12'hEEE, 12'hFFF, 12'h9F0, 1'b1);
        run_batches(8);
        apply_setting(CFG_DATA_W'($urandom_range(0, 1)),
                      CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(2048, 4095)),
                      CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(2048, 4095)),
                      CFG_DATA_W'($urandom_range(1, 1023)), CFG_DATA_W'($urandom_range(1, 1023)),
                      1'b0);
        run_batches(8);
        apply_setting(CFG_DATA_W'(RST_ORIENTATION), CFG_DATA_W'(RST_X_LOW), CFG_DATA_W'(RST_X_HIGH),
                      CFG_DATA_W'(RST_Y_LOW), CFG_DATA_W'(RST_Y_HIGH), CFG_DATA_W'(RST_SHORT),
                      CFG_DATA_W'(RST_LONG), 1'b0);
        run_batches(6);
    endtask

    task automatic test_random_stream(input int target);
        int start;
        int r;
        int chunk;
        start = n_samples;
        chunk = 0;
        while (n_samples - start < target)
        begin
            if (n_samples - start >= chunk)
            begin
                chunk += 60;
                no_gaps = ($urandom_range(0, 3) == 0);
                drift_x = RAW_W'($urandom_range(0, 4095));
                drift_y = RAW_W'($urandom_range(0, 4095));
                if ($urandom_range(0, 2) == 0)
                    wait_for_events();
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                send_batch(pick_shape());
            else if (r < 80)
                send_sample(1'b0, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
            else if (r < 90)
            begin
                repeat ($urandom_range(1, BATCH_LEN - 1))
                    send_sample(1'b1, RAW_W'($urandom_range(0, 4095)),
                                RAW_W'($urandom_range(0, 4095)));
                send_sample(1'b0, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
            end
            else
                send_sample(1'b1, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_left = LONG_HOLD_CYCLES;
        no_gaps   = 1'b1;
        repeat (10) send_batch(SHAPE_RANDOM);
        no_gaps = 1'b0;
        wait_for_events();
    endtask

    initial
    begin
        sample_ch.valid    = 1'b0;
        sample_ch.pen_down = 1'b0;
        sample_ch.raw_x    = '0;
        sample_ch.raw_y    = '0;
        reg_ch.valid       = 1'b0;
        reg_ch.index       = '0;
        reg_ch.data        = '0;
        event_ch.ready     = 1'b0;
        drift_x            = 12'd2048;
        drift_y            = 12'd2048;
        reset_filter_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings();
        test_random_stream(450);
        test_backpressure();
        settle();

        $display("covered %0d samples and %0d register writes across %0d setups",
                 n_samples, n_reg_writes, n_settings);
        $display("checked %0d down, %0d move, %0d up events with %0d mismatches",
                 n_down, n_move, n_up, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("timeout with %0d events still pending", pending_events.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> touch_sample_filter_event_core.f
+incdir+hdl
hdl/tsfe_pkg.sv
hdl/tsfe_if.sv
hdl/tsfe_cfg_regs.sv
hdl/tsfe_div.sv
hdl/touch_sample_filter_event_core.sv
sim/testbench.sv
